// ===== rtl/multi_camera_frame_grouper_defines.svh =====
// assertion helpers used by the command FIFO
`ifndef MULTI_CAMERA_FRAME_GROUPER_DEFINES_SVH
`define MULTI_CAMERA_FRAME_GROUPER_DEFINES_SVH

// same-cycle implication
`define MCFG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MCFG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mcfg_pkg.sv =====
package mcfg_pkg;

  localparam int KIND_W      = 2;
  localparam int CAMERA_W    = 2;
  localparam int HANDLE_W    = 32;
  localparam int TIME_W      = 48;
  localparam int GROUP_NUM_W = 32;
  localparam int MQL_W       = 4;
  localparam int CAMCNT_W    = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  // transaction kinds
  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GROUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_QUEUE_LEN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_COUNT  = 2'd1;

  localparam logic [MQL_W-1:0]    MQL_RESET    = 4'd4;
  localparam logic [CAMCNT_W-1:0] CAMCNT_RESET = 3'd1;

  // entries a queue is trimmed to when a group is taken
  localparam int TRIM_KEEP = 2;

  // depth of the queue between front and back
  localparam int CMDQ_DEPTH = 4;

  // command opcodes
  localparam logic [1:0] CMD_WRITE     = 2'd0;
  localparam logic [1:0] CMD_READ      = 2'd1;
  localparam logic [1:0] CMD_NOT_READY = 2'd2;

  localparam logic STATUS_EMIT      = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   end_time;
  } rec_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [CAMERA_W-1:0] camera;
    logic                last;
    rec_t                rec;
  } cmd_t;

  typedef struct packed {
    logic                   status;
    logic [CAMERA_W-1:0]    camera;
    logic [HANDLE_W-1:0]    handle;
    logic [TIME_W-1:0]      start_time;
    logic [TIME_W-1:0]      end_time;
    logic [TIME_W-1:0]      group_start;
    logic [TIME_W-1:0]      group_end;
    logic [GROUP_NUM_W-1:0] group_number;
    logic                   last;
  } res_t;

endpackage

// ===== rtl/multi_camera_frame_grouper.sv =====
// Multi-camera frame grouper. Keeps one bounded FIFO of frame records (handle,
// start and end timestamp) per camera and, on request, emits one frame per
// active camera as a group. The input side behaves like a queue: a transaction
// (kind 0 push, 1 group request, 2 clear) is taken when push is high and full is
// low. Results come out of a queue: while empty is low the oldest result is on
// the result ports, and pop takes it. A group request answers with one result
// per active camera (last set on the final one), or with a single not-ready
// result (status 1, last 1, all else zero) when some active queue is empty.
// Pushes with no camera, kind 3, pushes and clears produce no result. The
// configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 is max_queue_len, index 1 is camera_count, others are ignored.
// Write configuration only while the block is idle. The front handles a push or
// clear in its idle state; a group request moves it to its group state, where it
// issues one read command per active camera, holding while the command queue is
// full. The back end owns the single-port record memory; for each group member it
// reads the memory, then loads the result register, and takes no further command
// until that member is emitted. A four-entry command queue between front and
// back lets pushes keep arriving while results wait to be popped.
module multi_camera_frame_grouper #(
  parameter int MAX_CAMERAS = 4,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // input queue side
  input  logic                               push,
  output logic                               full,
  input  logic [mcfg_pkg::KIND_W-1:0]        kind,
  input  logic                               camera_present,
  input  logic [mcfg_pkg::CAMERA_W-1:0]      camera_index,
  input  logic [mcfg_pkg::HANDLE_W-1:0]      image_handle,
  input  logic [mcfg_pkg::TIME_W-1:0]        grab_start_time,
  input  logic [mcfg_pkg::TIME_W-1:0]        grab_end_time,
  // result queue side
  output logic                               empty,
  input  logic                               pop,
  output logic                               status,
  output logic [mcfg_pkg::CAMERA_W-1:0]      out_camera,
  output logic [mcfg_pkg::HANDLE_W-1:0]      out_handle,
  output logic [mcfg_pkg::TIME_W-1:0]        out_start_time,
  output logic [mcfg_pkg::TIME_W-1:0]        out_end_time,
  output logic [mcfg_pkg::TIME_W-1:0]        group_start_time,
  output logic [mcfg_pkg::TIME_W-1:0]        group_end_time,
  output logic [mcfg_pkg::GROUP_NUM_W-1:0]   group_number,
  output logic                               last,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mcfg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mcfg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mcfg_pkg::*;

  localparam int SLOTS  = MAX_CAMERAS * QUEUE_DEPTH;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CMD_W  = $bits(cmd_t) + SLOT_W;

  // configuration registers
  logic [MQL_W-1:0]    max_queue_len;
  logic [CAMCNT_W-1:0] camera_count;

  // front to command queue
  logic              accept;
  logic              front_busy;
  logic              fcmd_valid;
  cmd_t              fcmd;
  logic [SLOT_W-1:0] fcmd_slot;

  // command queue to back
  logic              cq_full;
  logic              cq_empty;
  logic              cq_rd;
  logic [CMD_W-1:0]  cq_rd_data;
  cmd_t              bcmd;
  logic [SLOT_W-1:0] bcmd_slot;

  // result register
  res_t res;
  logic res_valid;
  logic res_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_queue_len <= MQL_RESET;
      camera_count  <= CAMCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_QUEUE_LEN: max_queue_len <= cfg_data;
        REG_CAMERA_COUNT:  camera_count  <= cfg_data[CAMCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // hold off input while the front walks a group or the command queue is full
  assign full   = front_busy || cq_full;
  assign accept = push && !full;

  mcfg_front #(
    .MAX_CAMERAS (MAX_CAMERAS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SLOT_W      (SLOT_W)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .max_queue_len   (max_queue_len),
    .camera_count    (camera_count),
    .in_valid        (accept),
    .kind            (kind),
    .camera_present  (camera_present),
    .camera_index    (camera_index),
    .image_handle    (image_handle),
    .grab_start_time (grab_start_time),
    .grab_end_time   (grab_end_time),
    .busy            (front_busy),
    .cmd_valid       (fcmd_valid),
    .cmd             (fcmd),
    .cmd_slot        (fcmd_slot),
    .cmd_full        (cq_full)
  );

  // record writes and reads share one ordered queue, so a slot is never
  // overwritten before its pending read
  mcfg_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fcmd_valid),
    .wr_data ({fcmd_slot, fcmd}),
    .full    (cq_full),
    .rd_en   (cq_rd),
    .rd_data (cq_rd_data),
    .empty   (cq_empty)
  );

  assign bcmd      = cq_rd_data[$bits(cmd_t)-1:0];
  assign bcmd_slot = cq_rd_data[CMD_W-1:$bits(cmd_t)];

  mcfg_back #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (bcmd),
    .cmd_slot  (bcmd_slot),
    .cmd_empty (cq_empty),
    .cmd_rd    (cq_rd),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (res_pop)
  );

  // result queue side
  assign empty            = !res_valid;
  assign res_pop          = pop && res_valid;
  assign status           = res.status;
  assign out_camera       = res.camera;
  assign out_handle       = res.handle;
  assign out_start_time   = res.start_time;
  assign out_end_time     = res.end_time;
  assign group_start_time = res.group_start;
  assign group_end_time   = res.group_end;
  assign group_number     = res.group_number;
  assign last             = res.last;

endmodule

// ===== rtl/mcfg_cmd_fifo.sv =====
`include "multi_camera_frame_grouper_defines.svh"

module mcfg_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = data[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      data[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  `MCFG_ASSERT_IMPLY(a_no_overflow, clk, rst, wr_en, !full)
  `MCFG_ASSERT_IMPLY(a_no_underflow, clk, rst, rd_en, !empty)
  `MCFG_ASSERT_NEXT(a_write_lands, clk, rst, wr_en && !rd_en, !empty)

endmodule

// ===== rtl/mcfg_front.sv =====
module mcfg_front #(
  parameter int MAX_CAMERAS = 4,
  parameter int QUEUE_DEPTH = 8,
  parameter int SLOT_W      = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mcfg_pkg::MQL_W-1:0]      max_queue_len,
  input  logic [mcfg_pkg::CAMCNT_W-1:0]   camera_count,
  input  logic                            in_valid,
  input  logic [mcfg_pkg::KIND_W-1:0]     kind,
  input  logic                            camera_present,
  input  logic [mcfg_pkg::CAMERA_W-1:0]   camera_index,
  input  logic [mcfg_pkg::HANDLE_W-1:0]   image_handle,
  input  logic [mcfg_pkg::TIME_W-1:0]     grab_start_time,
  input  logic [mcfg_pkg::TIME_W-1:0]     grab_end_time,
  output logic                            busy,
  output logic                            cmd_valid,
  output mcfg_pkg::cmd_t                  cmd,
  output logic [SLOT_W-1:0]               cmd_slot,
  input  logic                            cmd_full
);
  import mcfg_pkg::*;

  localparam int HW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int CAM_W = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
  localparam int NC_W  = $clog2(MAX_CAMERAS + 1);

  localparam logic FS_IDLE  = 1'b0;
  localparam logic FS_GROUP = 1'b1;

  logic [0:0]    state;
  logic [CAM_W-1:0] cam_ptr;
  logic [HW-1:0] heads  [MAX_CAMERAS];
  logic [CW-1:0] counts [MAX_CAMERAS];

  logic [NC_W-1:0]  ncam;
  logic [CW-1:0]    lim;
  logic [CAM_W-1:0] cam_sel;
  logic [CAM_W-1:0] idx;
  logic [HW-1:0]    h;
  logic [CW-1:0]    c;
  logic [CW-1:0]    adv;
  logic [CW-1:0]    cnt_keep;
  logic [HW-1:0]    h_new;
  logic [HW-1:0]    pos;
  logic [CW-1:0]    trim;
  logic [HW-1:0]    g_head;
  logic [HW-1:0]    g_next;
  logic [CW-1:0]    g_cnt;
  logic             all_ready;
  logic             last_cam;

  function automatic logic [HW-1:0] wrap_add(logic [HW-1:0] a, logic [CW-1:0] b);
    logic [HW+1:0] s;
    s = (HW+2)'(a) + (HW+2)'(b);
    if (s >= (HW+2)'(QUEUE_DEPTH)) s = s - (HW+2)'(QUEUE_DEPTH);
    return s[HW-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(logic [CAM_W-1:0] cam, logic [HW-1:0] p);
    return SLOT_W'(cam) * SLOT_W'(QUEUE_DEPTH) + SLOT_W'(p);
  endfunction

  // clamp the configured values into range
  always_comb begin
    if (camera_count == '0) ncam = NC_W'(1);
    else if (int'(camera_count) > MAX_CAMERAS) ncam = NC_W'(MAX_CAMERAS);
    else ncam = NC_W'(camera_count);
    if (max_queue_len == '0) lim = CW'(1);
    else if (int'(max_queue_len) > QUEUE_DEPTH) lim = CW'(QUEUE_DEPTH);
    else lim = CW'(max_queue_len);
  end

  // unknown cameras fall back to camera 0
  assign cam_sel = (int'(camera_index) >= int'(ncam)) ? '0 : CAM_W'(camera_index);
  assign idx     = (state == FS_GROUP) ? cam_ptr : cam_sel;
  assign h       = heads[idx];
  assign c       = counts[idx];

  // push: drop oldest until there is room under the limit
  always_comb begin
    if (c >= lim) begin
      adv      = c - lim + CW'(1);
      cnt_keep = lim - CW'(1);
    end else begin
      adv      = '0;
      cnt_keep = c;
    end
  end
  assign h_new = wrap_add(h, adv);
  assign pos   = wrap_add(h_new, cnt_keep);

  // group: trim to the newest entries, then pop the front
  assign trim   = (c > CW'(TRIM_KEEP)) ? c - CW'(TRIM_KEEP) : '0;
  assign g_head = wrap_add(h, trim);
  assign g_next = wrap_add(g_head, CW'(1));
  assign g_cnt  = ((c > CW'(TRIM_KEEP)) ? CW'(TRIM_KEEP) : c) - CW'(1);

  always_comb begin
    all_ready = 1'b1;
    for (int i = 0; i < MAX_CAMERAS; i++) begin
      if (i < int'(ncam) && counts[i] == '0) all_ready = 1'b0;
    end
  end

  assign last_cam = (int'(cam_ptr) + 1 == int'(ncam));
  assign busy     = (state == FS_GROUP);

  always_comb begin
    cmd_valid = 1'b0;
    cmd       = '0;
    cmd_slot  = slot_of(idx, pos);
    case (state)
      FS_IDLE: begin
        if (in_valid && kind == KIND_PUSH && camera_present) begin
          cmd_valid              = 1'b1;
          cmd.op                 = CMD_WRITE;
          cmd.rec.handle         = image_handle;
          cmd.rec.start_time     = grab_start_time;
          cmd.rec.end_time       = grab_end_time;
        end else if (in_valid && kind == KIND_GROUP && !all_ready) begin
          cmd_valid = 1'b1;
          cmd.op    = CMD_NOT_READY;
          cmd.last  = 1'b1;
        end
      end
      FS_GROUP: begin
        if (!cmd_full) begin
          cmd_valid  = 1'b1;
          cmd.op     = CMD_READ;
          cmd.camera = CAMERA_W'(cam_ptr);
          cmd.last   = last_cam;
          cmd_slot   = slot_of(idx, g_head);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= FS_IDLE;
      cam_ptr <= '0;
      for (int i = 0; i < MAX_CAMERAS; i++) begin
        heads[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      case (state)
        FS_IDLE: begin
          if (in_valid) begin
            case (kind)
              KIND_PUSH: begin
                if (camera_present) begin
                  heads[idx]  <= h_new;
                  counts[idx] <= cnt_keep + CW'(1);
                end
              end
              KIND_GROUP: begin
                if (all_ready) begin
                  state   <= FS_GROUP;
                  cam_ptr <= '0;
                end
              end
              KIND_CLEAR: begin
                for (int i = 0; i < MAX_CAMERAS; i++) begin
                  heads[i]  <= '0;
                  counts[i] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        FS_GROUP: begin
          if (!cmd_full) begin
            heads[idx]  <= g_next;
            counts[idx] <= g_cnt;
            if (last_cam) state <= FS_IDLE;
            else cam_ptr <= cam_ptr + 1'b1;
          end
        end
        default: state <= FS_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/mcfg_back.sv =====
module mcfg_back #(
  parameter int SLOTS  = 32,
  parameter int SLOT_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  mcfg_pkg::cmd_t    cmd,
  input  logic [SLOT_W-1:0] cmd_slot,
  input  logic              cmd_empty,
  output logic              cmd_rd,
  output mcfg_pkg::res_t    res,
  output logic              res_valid,
  input  logic              res_pop
);
  import mcfg_pkg::*;

  localparam logic BS_IDLE = 1'b0;
  localparam logic BS_EMIT = 1'b1;

  rec_t mem [SLOTS];
  rec_t rd_rec;
  res_t res_nr;

  logic [0:0]             state;
  logic [CAMERA_W-1:0]    cam_q;
  logic                   last_q;
  logic [TIME_W-1:0]      gs;
  logic [TIME_W-1:0]      ge;
  logic [TIME_W-1:0]      gs_new;
  logic [TIME_W-1:0]      ge_new;
  logic [GROUP_NUM_W-1:0] groups_done;
  logic                   out_free;
  logic                   emit;
  logic                   res_valid_next;

  assign out_free = !res_valid || res_pop;
  assign cmd_rd   = (state == BS_IDLE) && !cmd_empty &&
                    (cmd.op != CMD_NOT_READY || out_free);
  assign emit     = (state == BS_EMIT) && out_free;

  // zero means unset for the running bounds
  assign gs_new = (gs == '0 || gs > rd_rec.start_time) ? rd_rec.start_time : gs;
  assign ge_new = (ge == '0 || ge < rd_rec.end_time) ? rd_rec.end_time : ge;

  // not-ready answer: status and last set, all else zero
  always_comb begin
    res_nr        = '0;
    res_nr.status = STATUS_NOT_READY;
    res_nr.last   = 1'b1;
  end

  // a loaded result wins over a pop in the same cycle
  always_comb begin
    res_valid_next = res_valid && !res_pop;
    if ((cmd_rd && cmd.op == CMD_NOT_READY) || emit) res_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd_rd && cmd.op == CMD_WRITE) begin
      mem[cmd_slot] <= cmd.rec;
    end
    if (cmd_rd && cmd.op == CMD_READ) begin
      rd_rec <= mem[cmd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_rd && cmd.op == CMD_NOT_READY) begin
      res <= res_nr;
    end else if (emit) begin
      res.status       <= STATUS_EMIT;
      res.camera       <= cam_q;
      res.handle       <= rd_rec.handle;
      res.start_time   <= rd_rec.start_time;
      res.end_time     <= rd_rec.end_time;
      res.group_start  <= gs_new;
      res.group_end    <= ge_new;
      res.group_number <= groups_done;
      res.last         <= last_q;
    end
    if (cmd_rd && cmd.op == CMD_READ) begin
      cam_q  <= cmd.camera;
      last_q <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BS_IDLE;
      res_valid   <= 1'b0;
      gs          <= '0;
      ge          <= '0;
      groups_done <= '0;
    end else begin
      res_valid <= res_valid_next;
      case (state)
        BS_IDLE: begin
          if (cmd_rd && cmd.op == CMD_READ) state <= BS_EMIT;
        end
        BS_EMIT: begin
          if (out_free) begin
            state <= BS_IDLE;
            if (last_q) begin
              gs          <= '0;
              ge          <= '0;
              groups_done <= groups_done + 1'b1;
            end else begin
              gs <= gs_new;
              ge <= ge_new;
            end
          end
        end
        default: state <= BS_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import mcfg_pkg::*;

  // sizes of the block as built here
  localparam int MAX_CAMERAS = 4;
  localparam int QUEUE_DEPTH = 8;

  // kind code the block does not define; it must be ignored
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // register indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  // cycles to let the back end drain pushes and clears that leave no result
  localparam int SETTLE_CYCLES = 40;
  // generous ceiling for the whole run
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 34;

  // one input transaction
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                present;
    logic [CAMERA_W-1:0] cam;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   t_start;
    logic [TIME_W-1:0]   t_end;
  } stim_t;

  // directed row: a transaction and, where obvious, the result it must give
  typedef struct packed {
    stim_t item;
    bit    typed;
    res_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   push = 1'b0;
  logic                   full;
  logic [KIND_W-1:0]      kind = '0;
  logic                   camera_present = 1'b0;
  logic [CAMERA_W-1:0]    camera_index = '0;
  logic [HANDLE_W-1:0]    image_handle = '0;
  logic [TIME_W-1:0]      grab_start_time = '0;
  logic [TIME_W-1:0]      grab_end_time = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic                   status;
  logic [CAMERA_W-1:0]    out_camera;
  logic [HANDLE_W-1:0]    out_handle;
  logic [TIME_W-1:0]      out_start_time;
  logic [TIME_W-1:0]      out_end_time;
  logic [TIME_W-1:0]      group_start_time;
  logic [TIME_W-1:0]      group_end_time;
  logic [GROUP_NUM_W-1:0] group_number;
  logic                   last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  multi_camera_frame_grouper #(
    .MAX_CAMERAS(MAX_CAMERAS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .kind(kind),
    .camera_present(camera_present),
    .camera_index(camera_index),
    .image_handle(image_handle),
    .grab_start_time(grab_start_time),
    .grab_end_time(grab_end_time),
    .empty(empty),
    .pop(pop),
    .status(status),
    .out_camera(out_camera),
    .out_handle(out_handle),
    .out_start_time(out_start_time),
    .out_end_time(out_end_time),
    .group_start_time(group_start_time),
    .group_end_time(group_end_time),
    .group_number(group_number),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow copy of the grouper: per-camera circular queues of frame records
  // ---------------------------------------------------------------------------
  rec_t                   frame_store [MAX_CAMERAS][QUEUE_DEPTH];
  logic [2:0]             q_head [MAX_CAMERAS];
  logic [3:0]             q_count [MAX_CAMERAS];
  logic [GROUP_NUM_W-1:0] groups_taken;
  logic [MQL_W-1:0]       queue_len_reg;
  logic [CAMCNT_W-1:0]    camera_count_reg;

  // results produced by the latest transaction, and all results still owed
  res_t emitted_members[$];
  res_t awaited_results[$];

  row_t directed_rows[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  groups_seen = 0;
  int  not_ready_seen = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  allow_idle = 1'b1;
  int unsigned pop_hold = 0;

  // out-of-range camera counts clamp to 1..MAX_CAMERAS
  function automatic int unsigned active_cams();
    int unsigned n;
    n = 32'(camera_count_reg);
    if (n == 0) n = 1;
    if (n > MAX_CAMERAS) n = MAX_CAMERAS;
    return n;
  endfunction

  // out-of-range queue lengths clamp to 1..QUEUE_DEPTH
  function automatic int unsigned depth_limit();
    int unsigned n;
    n = 32'(queue_len_reg);
    if (n == 0) n = 1;
    if (n > QUEUE_DEPTH) n = QUEUE_DEPTH;
    return n;
  endfunction

  function automatic void drop_oldest(int unsigned cam);
    if (q_count[cam] != 0) begin
      q_head[cam]  = q_head[cam] + 3'd1;
      q_count[cam] = q_count[cam] - 4'd1;
    end
  endfunction

  // applies one accepted transaction and leaves its results in emitted_members
  function automatic void update_frame_queues(stim_t it);
    int unsigned ncam;
    int unsigned cam;
    logic [2:0]  slot;
    logic [TIME_W-1:0] gs;
    logic [TIME_W-1:0] ge;
    bit ready;
    rec_t front;
    res_t r;
    emitted_members.delete();
    ncam = active_cams();
    case (it.kind)
      KIND_PUSH: begin
        if (it.present) begin
          cam = 32'(it.cam);
          // an index beyond the active cameras lands in camera 0
          if (cam >= ncam) cam = 0;
          while (32'(q_count[cam]) >= depth_limit()) drop_oldest(cam);
          slot = q_head[cam] + q_count[cam][2:0];
          frame_store[cam][slot].handle     = it.handle;
          frame_store[cam][slot].start_time = it.t_start;
          frame_store[cam][slot].end_time   = it.t_end;
          q_count[cam] = q_count[cam] + 4'd1;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < MAX_CAMERAS; i++) begin
          q_head[i]  = '0;
          q_count[i] = '0;
        end
      end
      KIND_GROUP: begin
        ready = 1'b1;
        for (int i = 0; i < ncam; i++) if (q_count[i] == 0) ready = 1'b0;
        if (!ready) begin
          r = '0;
          r.status = STATUS_NOT_READY;
          r.last   = 1'b1;
          emitted_members = {emitted_members, r};
        end else begin
          gs = '0;
          ge = '0;
          for (int i = 0; i < ncam; i++) begin
            while (32'(q_count[i]) > TRIM_KEEP) drop_oldest(i);
            front = frame_store[i][q_head[i]];
            // zero means no running value yet
            if (gs == 0 || gs > front.start_time) gs = front.start_time;
            if (ge == 0 || ge < front.end_time) ge = front.end_time;
            r.status       = STATUS_EMIT;
            r.camera       = i[CAMERA_W-1:0];
            r.handle       = front.handle;
            r.start_time   = front.start_time;
            r.end_time     = front.end_time;
            r.group_start  = gs;
            r.group_end    = ge;
            r.group_number = groups_taken;
            r.last         = (i + 1 == ncam);
            emitted_members = {emitted_members, r};
            drop_oldest(i);
          end
          groups_taken = groups_taken + 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic res_t not_ready();
    res_t r;
    r = '0;
    r.status = STATUS_NOT_READY;
    r.last   = 1'b1;
    return r;
  endfunction

  // the single member of a one-camera group
  function automatic res_t solo(logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] s,
                                logic [TIME_W-1:0] e, logic [GROUP_NUM_W-1:0] n);
    res_t r;
    r.status       = STATUS_EMIT;
    r.camera       = '0;
    r.handle       = h;
    r.start_time   = s;
    r.end_time     = e;
    r.group_start  = s;
    r.group_end    = e;
    r.group_number = n;
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic void add_row(logic [KIND_W-1:0] k, logic p, logic [CAMERA_W-1:0] c,
                                  logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] s,
                                  logic [TIME_W-1:0] e, bit typed, res_t want);
    row_t row;
    row.item  = {k, p, c, h, s, e};
    row.typed = typed;
    row.want  = want;
    directed_rows = {directed_rows, row};
  endfunction

  // timestamps lean on zero, all-ones and tiny values to stress the min/max
  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] w;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    w = {$urandom, $urandom};
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return TIME_W'($urandom_range(1, 15));
    return w[TIME_W-1:0];
  endfunction

  // mostly pushes to live cameras and group requests, some noise
  function automatic stim_t random_item(int unsigned ncam);
    stim_t it;
    int unsigned pick;
    pick       = $urandom_range(0, 99);
    it.kind    = KIND_PUSH;
    it.present = 1'b1;
    it.cam     = CAMERA_W'($urandom_range(0, ncam - 1));
    it.handle  = $urandom;
    it.t_start = rand_time();
    it.t_end   = rand_time();
    if (pick >= 60 && pick < 68) it.cam = CAMERA_W'($urandom_range(0, 3));
    else if (pick >= 68 && pick < 90) it.kind = KIND_GROUP;
    else if (pick >= 90 && pick < 94) it.kind = KIND_CLEAR;
    else if (pick >= 94 && pick < 97) it.present = 1'b0;
    else if (pick >= 97) it.kind = KIND_UNUSED;
    // non-push kinds still get random presence and index bits
    if (it.kind != KIND_PUSH) begin
      it.present = 1'($urandom_range(0, 1));
      it.cam     = CAMERA_W'($urandom_range(0, 3));
    end
    return it;
  endfunction

  // leaves push high on return so a back-to-back item needs no lowering
  task automatic send_item(input stim_t it, input bit typed, input res_t want);
    push            <= 1'b1;
    kind            <= it.kind;
    camera_present  <= it.present;
    camera_index    <= it.cam;
    image_handle    <= it.handle;
    grab_start_time <= it.t_start;
    grab_end_time   <= it.t_end;
    @(posedge clk);
    while (full) @(posedge clk);
    update_frame_queues(it);
    if (typed) awaited_results = {awaited_results, want};
    else foreach (emitted_members[i]) awaited_results = {awaited_results, emitted_members[i]};
    items_sent++;
  endtask

  task automatic input_gap();
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // leaves cfg_valid high on return, like send_item
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MAX_QUEUE_LEN) queue_len_reg = data[MQL_W-1:0];
    else if (idx == REG_CAMERA_COUNT) camera_count_reg = data[CAMCNT_W-1:0];
  endtask

  // all owed results in, then let trailing pushes and clears retire
  task automatic drain();
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h, cycle %0d", what, got, want,
             cycle_count);
    mismatches++;
  endtask

  task automatic check_result();
    res_t want;
    results_seen++;
    if (status == STATUS_NOT_READY) not_ready_seen++;
    else if (last) groups_seen++;
    if (awaited_results.size() == 0) begin
      flag("result with nothing owed, handle", 64'(out_handle), '0);
    end else begin
      want = awaited_results[0];
      awaited_results.delete(0);
      if (status !== want.status) flag("status", 64'(status), 64'(want.status));
      if (out_camera !== want.camera)
        flag("out_camera", 64'(out_camera), 64'(want.camera));
      if (out_handle !== want.handle)
        flag("out_handle", 64'(out_handle), 64'(want.handle));
      if (out_start_time !== want.start_time)
        flag("out_start_time", 64'(out_start_time), 64'(want.start_time));
      if (out_end_time !== want.end_time)
        flag("out_end_time", 64'(out_end_time), 64'(want.end_time));
      if (group_start_time !== want.group_start)
        flag("group_start_time", 64'(group_start_time), 64'(want.group_start));
      if (group_end_time !== want.group_end)
        flag("group_end_time", 64'(group_end_time), 64'(want.group_end));
      if (group_number !== want.group_number)
        flag("group_number", 64'(group_number), 64'(want.group_number));
      if (last !== want.last) flag("last", 64'(last), 64'(want.last));
    end
  endtask

  // result side: take a transaction whenever one is offered, with stall bursts
  always @(posedge clk) begin
    if (!rst && pop && !empty) check_result();
    if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if (allow_idle && $urandom_range(0, 7) == 0) pop_hold = $urandom_range(1, 13);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               awaited_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed rows, run with the reset settings: one camera, queue length four
  // ---------------------------------------------------------------------------
  initial begin
    // nothing queued yet
    add_row(KIND_GROUP, 1'b1, 2'd0, '0, '0, '0, 1'b1, not_ready());
    // push with no camera must leave the queues untouched
    add_row(KIND_PUSH, 1'b0, 2'd0, '1, '1, '1, 1'b0, '0);
    add_row(KIND_GROUP, 1'b0, 2'd3, '0, '0, '0, 1'b1, not_ready());
    // all-ones record
    add_row(KIND_PUSH, 1'b1, 2'd0, '1, '1, '1, 1'b0, '0);
    add_row(KIND_GROUP, 1'b1, 2'd0, '0, '0, '0, 1'b1, solo('1, '1, '1, 32'd0));
    // index 3 is unknown with one camera, so it goes to camera 0; zero times
    add_row(KIND_PUSH, 1'b1, 2'd3, '0, '0, '0, 1'b0, '0);
    add_row(KIND_GROUP, 1'b1, 2'd0, '0, '0, '0, 1'b1, solo('0, '0, '0, 32'd1));
    // unused kind does nothing
    add_row(KIND_UNUSED, 1'b1, 2'd0, 32'hdead_beef, 48'd1, 48'd1, 1'b0, '0);
    add_row(KIND_GROUP, 1'b1, 2'd0, '0, '0, '0, 1'b1, not_ready());
    // six pushes into a queue of four: the oldest get dropped
    add_row(KIND_PUSH, 1'b1, 2'd0, 32'h11, 48'h100, 48'h200, 1'b0, '0);
    add_row(KIND_PUSH, 1'b1, 2'd1, 32'h22, 48'h300, 48'h400, 1'b0, '0);
    add_row(KIND_PUSH, 1'b1, 2'd2, 32'h33, 48'h500, 48'h600, 1'b0, '0);
    add_row(KIND_PUSH, 1'b1, 2'd3, 32'h44, 48'h700, 48'h800, 1'b0, '0);
    add_row(KIND_PUSH, 1'b1, 2'd0, 32'h55, 48'h900, 48'ha00, 1'b0, '0);
    add_row(KIND_PUSH, 1'b1, 2'd1, 32'h66, 48'hb00, 48'hc00, 1'b0, '0);
    // trim to two, then drain them one group at a time
    add_row(KIND_GROUP, 1'b1, 2'd0, '0, '0, '0, 1'b0, '0);
    add_row(KIND_GROUP, 1'b1, 2'd0, '0, '0, '0, 1'b0, '0);
    add_row(KIND_GROUP, 1'b1, 2'd0, '0, '0, '0, 1'b1, not_ready());
    // clear throws away a queued frame
    add_row(KIND_PUSH, 1'b1, 2'd0, 32'h77, 48'hd00, 48'he00, 1'b0, '0);
    add_row(KIND_CLEAR, 1'b1, 2'd0, '0, '0, '0, 1'b0, '0);
    add_row(KIND_GROUP, 1'b1, 2'd0, '0, '0, '0, 1'b1, not_ready());
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // queue length / camera count per phase: clamped extremes first,
    // last phase runs four cameras with no idling on either side
    logic [MQL_W-1:0]    len_plan [PHASES];
    logic [CAMCNT_W-1:0] cam_plan [PHASES];
    int unsigned ncam;
    int useful;
    stim_t it;

    len_plan = '{4'd0, 4'd15, 4'd8, 4'd1, 4'd2, 4'd5, 4'd3, 4'd4};
    cam_plan = '{3'd0, 3'd7, 3'd4, 3'd4, 3'd2, 3'd3, 3'd6, 3'd4};

    for (int c = 0; c < MAX_CAMERAS; c++) begin
      q_head[c]  = '0;
      q_count[c] = '0;
    end
    groups_taken     = '0;
    queue_len_reg    = MQL_RESET;
    camera_count_reg = CAMCNT_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      input_gap();
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == PHASES - 1) allow_idle = 1'b0;
      write_reg(REG_MAX_QUEUE_LEN, len_plan[p]);
      // bit 3 lies above the camera count field and must be dropped
      write_reg(REG_CAMERA_COUNT, {1'($urandom_range(0, 1)), cam_plan[p]});
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                CFG_DATA_W'($urandom_range(0, 15)));
      cfg_valid <= 1'b0;
      ncam   = active_cams();
      useful = 0;
      while (useful < ITEMS_PER_PHASE) begin
        it = random_item(ncam);
        send_item(it, 1'b0, '0);
        if (it.kind != KIND_UNUSED && !(it.kind == KIND_PUSH && !it.present)) useful++;
        input_gap();
      end
    end

    drain();
    if (awaited_results.size() != 0)
      flag("results never delivered, count", 64'(awaited_results.size()), '0);

    $display("%0d input transactions over %0d register settings, %0d results checked",
             items_sent, PHASES + 1, results_seen);
    $display("%0d complete groups and %0d not-ready answers, %0d mismatches",
             groups_seen, not_ready_seen, mismatches);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
